// File: rtl/bmdt_pkg.sv
// Package with the shared types and codes of the divider/timer block.
package bmdt_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] reg_idx_t;
  typedef logic [7:0] byte_t;
  typedef logic [1:0] clk_sel_t;

  localparam kind_t KIND_TICK  = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_WRITE = 2'd2;

  localparam reg_idx_t REG_DIV  = 2'd0;
  localparam reg_idx_t REG_CNT  = 2'd1;
  localparam reg_idx_t REG_MOD  = 2'd2;
  localparam reg_idx_t REG_CTRL = 2'd3;

  localparam clk_sel_t SEL_DIV_BIT10 = 2'd0;
  localparam clk_sel_t SEL_DIV_BIT4  = 2'd1;
  localparam clk_sel_t SEL_DIV_BIT6  = 2'd2;
  localparam clk_sel_t SEL_DIV_BIT8  = 2'd3;

  localparam int CTRL_EN_BIT = 2;

  localparam logic [15:0] DIV_RESET  = 16'hAB00;
  localparam byte_t       CTRL_RESET = 8'hF8;
  localparam byte_t       CNT_MAX    = 8'hFF;

  localparam logic [2:0] TICK_IRQ      = 3'd4;
  localparam logic [2:0] TICK_RELOAD_A = 3'd5;
  localparam logic [2:0] TICK_RELOAD_B = 3'd6;

  typedef struct packed {
    byte_t read_data;
    logic  timer_interrupt;
  } result_t;

endpackage

// File: rtl/bmdt_if.sv
// Stream interfaces for the input beats and the result beats.
interface bmdt_in_if;
  logic              valid;
  logic              ready;
  bmdt_pkg::kind_t    kind;
  bmdt_pkg::reg_idx_t reg_index;
  bmdt_pkg::byte_t    write_data;

  modport source (output valid, output kind, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input kind, input reg_index, input write_data,
                output ready);
endinterface

interface bmdt_out_if;
  logic            valid;
  logic            ready;
  bmdt_pkg::byte_t read_data;
  logic            timer_interrupt;

  modport source (output valid, output read_data, output timer_interrupt,
                  input ready);
  modport sink (input valid, input read_data, input timer_interrupt,
                output ready);
endinterface

// File: rtl/bmdt_core.sv
// Timer state registers and the per-beat update and read logic.
module bmdt_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  bmdt_pkg::kind_t     kind,
  input  bmdt_pkg::reg_idx_t  reg_index,
  input  bmdt_pkg::byte_t     write_data,
  output bmdt_pkg::result_t   result
);

  logic [15:0]     divider_r, divider_nxt;
  bmdt_pkg::byte_t counter_r, counter_nxt;
  bmdt_pkg::byte_t modulo_r, modulo_nxt;
  bmdt_pkg::byte_t control_r, control_nxt;
  logic            pending_r, pending_nxt;
  logic [2:0]      ticks_r, ticks_nxt;
  logic            last_bit_r, last_bit_nxt;

  always_comb begin
    logic [2:0] tk;
    logic       sel;
    divider_nxt  = divider_r;
    counter_nxt  = counter_r;
    modulo_nxt   = modulo_r;
    control_nxt  = control_r;
    pending_nxt  = pending_r;
    ticks_nxt    = ticks_r;
    last_bit_nxt = last_bit_r;
    result       = '0;
    tk           = ticks_r + 3'd1;
    sel          = 1'b0;
    case (kind)
      bmdt_pkg::KIND_TICK: begin
        divider_nxt = divider_r + 16'd1;
        if (pending_r) begin
          ticks_nxt = tk;
          if (tk == bmdt_pkg::TICK_IRQ) begin
            result.timer_interrupt = 1'b1;
          end else if (tk == bmdt_pkg::TICK_RELOAD_A) begin
            counter_nxt = modulo_r;
          end else if (tk == bmdt_pkg::TICK_RELOAD_B) begin
            counter_nxt = modulo_r;
            pending_nxt = 1'b0;
            ticks_nxt   = 3'd0;
          end
        end
        case (control_r[1:0])
          bmdt_pkg::SEL_DIV_BIT10: sel = divider_nxt[10];
          bmdt_pkg::SEL_DIV_BIT4:  sel = divider_nxt[4];
          bmdt_pkg::SEL_DIV_BIT6:  sel = divider_nxt[6];
          default:                 sel = divider_nxt[8];
        endcase
        if (control_r[bmdt_pkg::CTRL_EN_BIT] && (sel != last_bit_r)) begin
          if (counter_nxt == bmdt_pkg::CNT_MAX) begin
            pending_nxt = 1'b1;
          end
          counter_nxt  = counter_nxt + 8'd1;
          last_bit_nxt = sel;
        end
      end
      bmdt_pkg::KIND_READ: begin
        case (reg_index)
          bmdt_pkg::REG_DIV: result.read_data = divider_r[15:8];
          bmdt_pkg::REG_CNT: result.read_data = counter_r;
          bmdt_pkg::REG_MOD: result.read_data = modulo_r;
          default:           result.read_data = control_r;
        endcase
      end
      bmdt_pkg::KIND_WRITE: begin
        case (reg_index)
          bmdt_pkg::REG_DIV: divider_nxt = '0;
          bmdt_pkg::REG_CNT: counter_nxt = write_data;
          bmdt_pkg::REG_MOD: modulo_nxt  = write_data;
          default:           control_nxt = write_data;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r  <= bmdt_pkg::DIV_RESET;
      counter_r  <= '0;
      modulo_r   <= '0;
      control_r  <= bmdt_pkg::CTRL_RESET;
      pending_r  <= 1'b0;
      ticks_r    <= '0;
      last_bit_r <= 1'b0;
    end else if (accept) begin
      divider_r  <= divider_nxt;
      counter_r  <= counter_nxt;
      modulo_r   <= modulo_nxt;
      control_r  <= control_nxt;
      pending_r  <= pending_nxt;
      ticks_r    <= ticks_nxt;
      last_bit_r <= last_bit_nxt;
    end
  end

endmodule

// File: rtl/bmdt_out_reg.sv
// Result register that holds one beat for the output channel.
module bmdt_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bmdt_pkg::result_t result,
  output logic              can_load,
  bmdt_out_if.source        out_bus
);

  logic              valid_r, valid_nxt;
  bmdt_pkg::result_t data_r;

  assign can_load  = !valid_r || out_bus.ready;
  assign valid_nxt = load || (valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_bus.valid           = valid_r;
  assign out_bus.read_data       = data_r.read_data;
  assign out_bus.timer_interrupt = data_r.timer_interrupt;

endmodule

// File: rtl/bus_mapped_divider_timer_top.sv
// Top level of the bus-mapped divider/counter timer.
// The input channel in_bus carries one beat per tick, bus read or bus write
// (kind, reg_index, write_data). The output channel out_bus returns exactly
// one beat per input beat, in order, with read_data and timer_interrupt.
// Each accepted beat updates the timer state at the clock edge that takes
// it, and its result is loaded into the output register at that same edge.
// Throughput is one beat per cycle while out_bus ready is high; the rate
// is set by the single result register behind the update logic.
// When the receiver stalls, the result register holds its beat and in_bus
// ready stays high only while that register is empty or being drained in
// the same cycle, so no beat is lost or repeated.
// Reset puts the divider at 0xAB00, control at 0xF8 and all other state at
// zero, and empties the result register.
module bus_mapped_divider_timer_top (
  input  logic       clk,
  input  logic       rst_n,
  bmdt_in_if.sink    in_bus,
  bmdt_out_if.source out_bus
);

  logic              accept;
  logic              can_load;
  bmdt_pkg::result_t result;

  assign in_bus.ready = can_load;
  assign accept       = in_bus.valid && can_load;

  bmdt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .kind       (in_bus.kind),
    .reg_index  (in_bus.reg_index),
    .write_data (in_bus.write_data),
    .result     (result)
  );

  bmdt_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .result   (result),
    .can_load (can_load),
    .out_bus  (out_bus)
  );

endmodule

// File: sim/tb_bus_mapped_divider_timer_top.sv
// Self-checking testbench for the bus-mapped divider/counter timer top level.
module tb_bus_mapped_divider_timer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bmdt_pkg::kind_t KIND_UNUSED = 2'd3;
  localparam int              HOLD_CYCLES = 300;
  localparam int              CYCLE_LIMIT = 200000;

  typedef struct packed {
    bmdt_pkg::kind_t    kind;
    bmdt_pkg::reg_idx_t idx;
    bmdt_pkg::byte_t    data;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst_n;

  bmdt_in_if  in_bus();
  bmdt_out_if out_bus();

  bus_mapped_divider_timer_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #1 clk = ~clk;

  bus_item_t           pending_items[$];
  bmdt_pkg::result_t   expected_results[$];
  int unsigned         items_queued;
  int unsigned         fail_count;
  int unsigned         cycle_count;
  int unsigned         sender_idle_pct;
  int unsigned         receiver_idle_pct;
  int unsigned         hold_requests;
  int unsigned         holds_served;
  int unsigned         hold_left;
  logic                in_took;

  logic [15:0]     div_q;
  bmdt_pkg::byte_t cnt_q;
  bmdt_pkg::byte_t mod_q;
  bmdt_pkg::byte_t ctrl_q;
  logic            ovf_pending;
  logic [2:0]      ovf_ticks;
  logic            last_sel;

  function automatic bmdt_pkg::result_t timer_predict(bmdt_pkg::kind_t kind,
                                                      bmdt_pkg::reg_idx_t idx,
                                                      bmdt_pkg::byte_t data);
    bmdt_pkg::result_t res;
    logic              sel_bit;
    res = '0;
    case (kind)
      bmdt_pkg::KIND_TICK: begin
        div_q = div_q + 16'd1;
        if (ovf_pending) begin
          ovf_ticks = ovf_ticks + 3'd1;
          if (ovf_ticks == bmdt_pkg::TICK_IRQ) begin
            res.timer_interrupt = 1'b1;
          end else if (ovf_ticks == bmdt_pkg::TICK_RELOAD_A) begin
            cnt_q = mod_q;
          end else if (ovf_ticks == bmdt_pkg::TICK_RELOAD_B) begin
            cnt_q = mod_q;
            ovf_pending = 1'b0;
            ovf_ticks = 3'd0;
          end
        end
        if (ctrl_q[bmdt_pkg::CTRL_EN_BIT]) begin
          case (ctrl_q[1:0])
            bmdt_pkg::SEL_DIV_BIT10: sel_bit = div_q[10];
            bmdt_pkg::SEL_DIV_BIT4:  sel_bit = div_q[4];
            bmdt_pkg::SEL_DIV_BIT6:  sel_bit = div_q[6];
            default:                 sel_bit = div_q[8];
          endcase
          if (sel_bit != last_sel) begin
            if (cnt_q == bmdt_pkg::CNT_MAX) begin
              ovf_pending = 1'b1;
            end
            cnt_q = cnt_q + 8'd1;
            last_sel = sel_bit;
          end
        end
      end
      bmdt_pkg::KIND_READ: begin
        case (idx)
          bmdt_pkg::REG_DIV: res.read_data = div_q[15:8];
          bmdt_pkg::REG_CNT: res.read_data = cnt_q;
          bmdt_pkg::REG_MOD: res.read_data = mod_q;
          default:           res.read_data = ctrl_q;
        endcase
      end
      bmdt_pkg::KIND_WRITE: begin
        case (idx)
          bmdt_pkg::REG_DIV: div_q = 16'd0;
          bmdt_pkg::REG_CNT: cnt_q = data;
          bmdt_pkg::REG_MOD: mod_q = data;
          default:           ctrl_q = data;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic push_item(bmdt_pkg::kind_t kind, bmdt_pkg::reg_idx_t idx,
                           bmdt_pkg::byte_t data);
    bus_item_t item;
    item.kind = kind;
    item.idx = idx;
    item.data = data;
    pending_items.push_back(item);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Mostly overflow runs: arm the timer near wrap-around, then tick through the
  // reload sequence with reads and writes mixed in. The rest is unstructured.
  task automatic queue_random_phase(int unsigned n_items);
    int unsigned        start;
    int unsigned        n_ticks;
    int unsigned        roll;
    bmdt_pkg::clk_sel_t sel;
    bmdt_pkg::byte_t    ctrl_val;
    start = items_queued;
    while (items_queued - start < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        sel = ($urandom_range(0, 3) == 0) ? bmdt_pkg::SEL_DIV_BIT6 : bmdt_pkg::SEL_DIV_BIT4;
        ctrl_val = bmdt_pkg::byte_t'($urandom);
        ctrl_val[bmdt_pkg::CTRL_EN_BIT] = 1'b1;
        ctrl_val[1:0] = sel;
        push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_CTRL, ctrl_val);
        push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_MOD, bmdt_pkg::byte_t'($urandom));
        push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_CNT,
                  bmdt_pkg::CNT_MAX - bmdt_pkg::byte_t'($urandom_range(0,
                    (sel == bmdt_pkg::SEL_DIV_BIT4) ? 3 : 1)));
        n_ticks = (sel == bmdt_pkg::SEL_DIV_BIT4) ? $urandom_range(40, 90)
                                                  : $urandom_range(70, 160);
        repeat (n_ticks) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            push_item(bmdt_pkg::KIND_READ, bmdt_pkg::reg_idx_t'($urandom),
                      bmdt_pkg::byte_t'($urandom));
          end else if (roll < 11) begin
            push_item(bmdt_pkg::KIND_WRITE,
                      $urandom_range(0, 1) ? bmdt_pkg::REG_CNT : bmdt_pkg::REG_MOD,
                      bmdt_pkg::byte_t'($urandom));
          end else if (roll < 12) begin
            push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_DIV, bmdt_pkg::byte_t'($urandom));
          end else begin
            push_item(bmdt_pkg::KIND_TICK, bmdt_pkg::reg_idx_t'($urandom),
                      bmdt_pkg::byte_t'($urandom));
          end
        end
      end else begin
        repeat (8) begin
          push_item(bmdt_pkg::kind_t'($urandom_range(0, 3)), bmdt_pkg::reg_idx_t'($urandom),
                    bmdt_pkg::byte_t'($urandom));
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_took) begin
        pending_items.delete(0);
      end
      if (!(in_bus.valid && !in_took)) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_bus.valid      <= 1'b1;
          in_bus.kind       <= pending_items[0].kind;
          in_bus.reg_index  <= pending_items[0].idx;
          in_bus.write_data <= pending_items[0].data;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(timer_predict(in_bus.kind, in_bus.reg_index,
                                                 in_bus.write_data));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation: read_data %0h timer_interrupt %0b",
                 out_bus.read_data, out_bus.timer_interrupt);
          fail_count++;
        end else begin
          if (out_bus.read_data !== expected_results[0].read_data) begin
            $error("read_data: expected %0h, actual %0h",
                   expected_results[0].read_data, out_bus.read_data);
            fail_count++;
          end
          if (out_bus.timer_interrupt !== expected_results[0].timer_interrupt) begin
            $error("timer_interrupt: expected %0b, actual %0b",
                   expected_results[0].timer_interrupt, out_bus.timer_interrupt);
            fail_count++;
          end
          expected_results.delete(0);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = bmdt_pkg::KIND_TICK;
    in_bus.reg_index = bmdt_pkg::REG_DIV;
    in_bus.write_data = 8'h00;
    out_bus.ready = 1'b0;
    in_took = 1'b0;
    items_queued = 0;
    fail_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_requests = 0;
    holds_served = 0;
    hold_left = 0;
    div_q = bmdt_pkg::DIV_RESET;
    cnt_q = 8'h00;
    mod_q = 8'h00;
    ctrl_q = bmdt_pkg::CTRL_RESET;
    ovf_pending = 1'b0;
    ovf_ticks = 3'd0;
    last_sel = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Reset values, the unused kind, then an overflow that is hit again while
    // its reload sequence is running, with a counter write in the middle.
    push_item(bmdt_pkg::KIND_READ, bmdt_pkg::REG_DIV, 8'h00);
    push_item(bmdt_pkg::KIND_READ, bmdt_pkg::REG_CNT, 8'hFF);
    push_item(bmdt_pkg::KIND_READ, bmdt_pkg::REG_MOD, 8'h00);
    push_item(bmdt_pkg::KIND_READ, bmdt_pkg::REG_CTRL, 8'hFF);
    push_item(KIND_UNUSED, bmdt_pkg::REG_CTRL, 8'hFF);
    push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_MOD, 8'h5A);
    push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_CNT, bmdt_pkg::CNT_MAX);
    push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_CTRL, {5'd0, 1'b1, bmdt_pkg::SEL_DIV_BIT8});
    push_item(bmdt_pkg::KIND_TICK, bmdt_pkg::REG_DIV, 8'h00);
    push_item(bmdt_pkg::KIND_TICK, bmdt_pkg::REG_CTRL, 8'hFF);
    push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_CNT, bmdt_pkg::CNT_MAX);
    push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_CTRL, {5'd0, 1'b1, bmdt_pkg::SEL_DIV_BIT10});
    repeat (3) push_item(bmdt_pkg::KIND_TICK, bmdt_pkg::REG_DIV, 8'h00);
    push_item(bmdt_pkg::KIND_READ, bmdt_pkg::REG_CNT, 8'h00);
    repeat (2) push_item(bmdt_pkg::KIND_TICK, bmdt_pkg::REG_DIV, 8'h00);
    push_item(bmdt_pkg::KIND_READ, bmdt_pkg::REG_CNT, 8'h00);
    push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_DIV, 8'hFF);
    push_item(bmdt_pkg::KIND_READ, bmdt_pkg::REG_DIV, 8'h00);
    push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_CTRL, 8'hFF);
    push_item(bmdt_pkg::KIND_READ, bmdt_pkg::REG_CTRL, 8'h00);
    push_item(bmdt_pkg::KIND_WRITE, bmdt_pkg::REG_CTRL, 8'h00);
    repeat (2) push_item(bmdt_pkg::KIND_TICK, bmdt_pkg::REG_CNT, 8'h00);
    wait_drained();

    sender_idle_pct = 38;
    receiver_idle_pct = 65;
    queue_random_phase(500);
    wait_drained();

    sender_idle_pct = 65;
    receiver_idle_pct = 38;
    queue_random_phase(500);
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    queue_random_phase(500);
    hold_requests = hold_requests + 1;
    wait_drained();

    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bmdt_pkg.sv
rtl/bmdt_if.sv
rtl/bmdt_core.sv
rtl/bmdt_out_reg.sv
rtl/bus_mapped_divider_timer_top.sv
sim/tb_bus_mapped_divider_timer_top.sv
